[sv/maspf_pkg.sv]
// Package for the multiturn angle spring force block.
// Holds register indexes, reset values, opcodes and the stage record type.
// No dependencies.
package maspf_pkg;

    localparam int unsigned CfgIdxW = 3;

    localparam logic [CfgIdxW-1:0] CFG_FLIP_THRESHOLD  = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_COUNTS_PER_FLIP = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_SPRING_CENTER   = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_FORCE_SHIFT     = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_DUTY_SCALE      = 3'd4;

    localparam logic [9:0]  RST_FLIP_THRESHOLD  = 10'd600;
    localparam logic [10:0] RST_COUNTS_PER_FLIP = 11'd700;
    localparam logic [15:0] RST_SPRING_CENTER   = 16'd800;
    localparam logic [3:0]  RST_FORCE_SHIFT     = 4'd6;
    localparam logic [15:0] RST_DUTY_SCALE      = 16'd5000;

    localparam logic OP_CALIBRATE = 1'b0;
    localparam logic OP_SAMPLE    = 1'b1;

    typedef struct packed {
        logic        valid;
        logic [9:0]  raw;
        logic [15:0] flip_count;
        logic [9:0]  zero;
    } unwrap_word_t;

endpackage

[sv/multiturn_angle_spring_force.sv]
// Top level of the multiturn angle spring force block.
// Depends on maspf_pkg and maspf_unwrap.
//
// Usage:
//   Input words arrive on s_tvalid/s_tready; s_tuser carries the opcode
//   (0 calibrate, 1 sample) and s_tdata the 10-bit angle reading.
//   A calibrate word stores the zero position and seeds the sample history;
//   it gives no result. Each sample word gives one result word on
//   m_tvalid/m_tready with force, drive direction, duty and position.
//   Each sample passes through the unwrap register, position register,
//   force register and output register in that order.
//   Throughput: one word per cycle; each stage holds independently, so
//   bubbles fill while the receiver stalls and s_tready drops only when
//   every stage holds a word. A stalled result holds its value.
//   Configuration: cfg_we writes cfg_data into the register at cfg_index
//   (0 flip_threshold, 1 counts_per_flip, 2 spring_center, 3 force_shift,
//   4 duty_scale); write only while no word is in flight.
//   Reset (rst_n low, asynchronous) empties the pipeline, clears the
//   history, flip flag, flip count and zero position, and loads the
//   register defaults.
module multiturn_angle_spring_force
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [9:0] raw_angle, rest zero
    input  logic        s_tuser,   // [0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [10:0] force_res, [11] drive_reverse,
                                   // [27:12] duty, [43:28] position, rest zero
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic [9:0]  thr_reg;
    logic [10:0] cpf_reg;
    logic [15:0] center_reg;
    logic [3:0]  shift_reg;
    logic [15:0] scale_reg;

    maspf_pkg::unwrap_word_t uw;

    logic               pos_valid_reg, pos_valid_next;
    logic [15:0]        pos_reg, pos_next;
    logic               frc_valid_reg, frc_valid_next;
    logic signed [10:0] frc_reg, frc_next;
    logic [15:0]        frc_pos_reg, frc_pos_next;
    logic               out_valid_reg, out_valid_next;
    logic [47:0]        out_reg, out_next;

    logic en_out, en_frc, en_pos, en_uw;

    logic [15:0]        prod_pos;
    logic [15:0]        cum;
    logic signed [16:0] d;
    logic signed [16:0] d_shift;
    logic [10:0]        mag_f;
    logic [26:0]        prod_duty;
    logic [15:0]        duty;

    assign en_out   = !out_valid_reg || m_tready;
    assign en_frc   = !frc_valid_reg || en_out;
    assign en_pos   = !pos_valid_reg || en_frc;
    assign en_uw    = !uw.valid || en_pos;
    assign s_tready = en_uw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg    <= maspf_pkg::RST_FLIP_THRESHOLD;
            cpf_reg    <= maspf_pkg::RST_COUNTS_PER_FLIP;
            center_reg <= maspf_pkg::RST_SPRING_CENTER;
            shift_reg  <= maspf_pkg::RST_FORCE_SHIFT;
            scale_reg  <= maspf_pkg::RST_DUTY_SCALE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                maspf_pkg::CFG_FLIP_THRESHOLD:  thr_reg    <= cfg_data[9:0];
                maspf_pkg::CFG_COUNTS_PER_FLIP: cpf_reg    <= cfg_data[10:0];
                maspf_pkg::CFG_SPRING_CENTER:   center_reg <= cfg_data;
                maspf_pkg::CFG_FORCE_SHIFT:     shift_reg  <= cfg_data[3:0];
                maspf_pkg::CFG_DUTY_SCALE:      scale_reg  <= cfg_data;
                default:                        ;
            endcase
        end
    end

    maspf_unwrap u_unwrap
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .load           (en_uw),
        .take           (s_tvalid),
        .op             (s_tuser),
        .raw_angle      (s_tdata[9:0]),
        .flip_threshold (thr_reg),
        .word           (uw)
    );

    always_comb
    begin
        prod_pos = 16'(uw.flip_count * cpf_reg);
        cum      = 16'({6'd0, uw.raw} + prod_pos);
        pos_next       = en_pos ? 16'(cum - {6'd0, uw.zero}) : pos_reg;
        pos_valid_next = en_pos ? uw.valid : pos_valid_reg;

        d       = $signed({center_reg[15], center_reg}) - $signed({pos_reg[15], pos_reg});
        d_shift = d >>> shift_reg;
        frc_next     = frc_reg;
        frc_pos_next = frc_pos_reg;
        if (en_frc)
        begin
            priority if (d_shift > 17'sd1023)
                frc_next = 11'sd1023;
            else if (d_shift < -17'sd1024)
                frc_next = -11'sd1024;
            else
                frc_next = d_shift[10:0];
            frc_pos_next = pos_reg;
        end
        frc_valid_next = en_frc ? pos_valid_reg : frc_valid_reg;

        mag_f     = frc_reg[10] ? 11'(-frc_reg) : frc_reg;
        prod_duty = 27'(mag_f * scale_reg);
        duty      = (prod_duty[26:16] != 11'd0) ? 16'hFFFF : prod_duty[15:0];
        out_next       = en_out ? {4'd0, frc_pos_reg, duty, frc_reg[10], frc_reg} : out_reg;
        out_valid_next = en_out ? frc_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_valid_reg <= 1'b0;
            frc_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_valid_reg <= pos_valid_next;
            frc_valid_reg <= frc_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg     <= pos_next;
        frc_reg     <= frc_next;
        frc_pos_reg <= frc_pos_next;
        out_reg     <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

endmodule

[sv/maspf_unwrap.sv]
// Wrap tracker: sample history, flip flag, flip count and zero position.
// Registers each accepted sample with its updated flip count.
// Depends on maspf_pkg.
module maspf_unwrap
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    load,
    input  logic                    take,
    input  logic                    op,
    input  logic [9:0]              raw_angle,
    input  logic [9:0]              flip_threshold,
    output maspf_pkg::unwrap_word_t word
);

    logic [9:0]  prev_reg, prev_next;
    logic [9:0]  prev_prev_reg, prev_prev_next;
    logic        flag_reg, flag_next;
    logic [15:0] count_reg, count_next;
    logic [9:0]  zero_reg, zero_next;
    maspf_pkg::unwrap_word_t word_reg, word_next;

    logic signed [10:0] diff;
    logic [9:0]         mag;

    always_comb
    begin
        diff = $signed({1'b0, raw_angle}) - $signed({1'b0, prev_prev_reg});
        mag  = diff[10] ? 10'(-diff) : diff[9:0];

        prev_next      = prev_reg;
        prev_prev_next = prev_prev_reg;
        flag_next      = flag_reg;
        count_next     = count_reg;
        zero_next      = zero_reg;
        word_next      = word_reg;

        if (load)
        begin
            word_next.valid = 1'b0;
            if (take)
            begin
                if (op == maspf_pkg::OP_CALIBRATE)
                begin
                    zero_next      = raw_angle;
                    prev_next      = raw_angle;
                    prev_prev_next = raw_angle;
                end
                else
                begin
                    prev_prev_next = prev_reg;
                    prev_next      = raw_angle;
                    if (mag > flip_threshold && !flag_reg)
                    begin
                        count_next = (!diff[10] && diff != 11'sd0) ? count_reg - 16'd1
                                                                   : count_reg + 16'd1;
                        flag_next  = 1'b1;
                    end
                    else
                    begin
                        flag_next = 1'b0;
                    end
                    word_next.valid      = 1'b1;
                    word_next.raw        = raw_angle;
                    word_next.flip_count = count_next;
                    word_next.zero       = zero_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg      <= '0;
            prev_prev_reg <= '0;
            flag_reg      <= 1'b0;
            count_reg     <= '0;
            zero_reg      <= '0;
            word_reg      <= '0;
        end
        else
        begin
            prev_reg      <= prev_next;
            prev_prev_reg <= prev_prev_next;
            flag_reg      <= flag_next;
            count_reg     <= count_next;
            zero_reg      <= zero_next;
            word_reg      <= word_next;
        end
    end

    assign word = word_reg;

endmodule

[verif/tb_multiturn_angle_spring_force.sv]
// Self-checking bench for multiturn_angle_spring_force: directed table then random sweeps.
// Predicts unwrap, spring force, drive direction and duty per sample word.
// Depends on maspf_pkg and the multiturn_angle_spring_force RTL.
`timescale 1ns / 100ps

module tb_multiturn_angle_spring_force;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned DIR_ROWS     = 24;
    localparam int unsigned PHASES       = 6;
    localparam int unsigned PHASE_WORDS  = 140;
    localparam int unsigned SETTLE       = 10;
    localparam int unsigned MAX_PRINTS   = 40;

    typedef struct packed {
        logic [10:0] force_val;
        logic        reverse;
        logic [15:0] duty;
        logic [15:0] pos;
    } spring_out_t;

    typedef struct packed {
        logic        op;
        logic [9:0]  raw;
        logic        pinned;
        spring_out_t want;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    logic [9:0]  thr_q;
    logic [10:0] cpf_q;
    logic [15:0] center_q;
    logic [3:0]  shift_q;
    logic [15:0] scale_q;

    logic [9:0]  angle_hist1;
    logic [9:0]  angle_hist2;
    logic        wrap_flag;
    logic [15:0] wrap_count;
    logic [9:0]  zero_angle;

    spring_out_t pending_spring[$];
    int unsigned error_cnt = 0;
    int unsigned cycle_cnt = 0;
    int unsigned snd_idle_pct = 21;
    int unsigned rcv_idle_pct = 51;
    logic [9:0]  sweep_angle = '0;

    stim_row_t dir_rows [0:DIR_ROWS-1] = '{
        '{maspf_pkg::OP_SAMPLE,    10'd0,    1'b1, '{11'd12, 1'b0, 16'd60000, 16'd0}},
        '{maspf_pkg::OP_SAMPLE,    10'd1023, 1'b1, '{11'd7,  1'b0, 16'd35000, 16'd323}},
        '{maspf_pkg::OP_SAMPLE,    10'd1023, 1'b0, '0},
        '{maspf_pkg::OP_SAMPLE,    10'd0,    1'b0, '0},
        '{maspf_pkg::OP_CALIBRATE, 10'd512,  1'b0, '0},
        '{maspf_pkg::OP_SAMPLE,    10'd512,  1'b0, '0},
        '{maspf_pkg::OP_SAMPLE,    10'd1023, 1'b0, '0},
        '{maspf_pkg::OP_SAMPLE,    10'd0,    1'b0, '0},
        '{maspf_pkg::OP_CALIBRATE, 10'd1000, 1'b0, '0},
        '{maspf_pkg::OP_SAMPLE,    10'd1000, 1'b0, '0},
        '{maspf_pkg::OP_SAMPLE,    10'd10,   1'b0, '0},
        '{maspf_pkg::OP_SAMPLE,    10'd20,   1'b0, '0},
        '{maspf_pkg::OP_SAMPLE,    10'd990,  1'b0, '0},
        '{maspf_pkg::OP_CALIBRATE, 10'd0,    1'b0, '0},
        '{maspf_pkg::OP_SAMPLE,    10'd0,    1'b0, '0},
        '{maspf_pkg::OP_SAMPLE,    10'd600,  1'b0, '0},
        '{maspf_pkg::OP_SAMPLE,    10'd601,  1'b0, '0},
        '{maspf_pkg::OP_CALIBRATE, 10'd1023, 1'b0, '0},
        '{maspf_pkg::OP_SAMPLE,    10'd0,    1'b0, '0},
        '{maspf_pkg::OP_CALIBRATE, 10'd0,    1'b0, '0},
        '{maspf_pkg::OP_SAMPLE,    10'd1000, 1'b0, '0},
        '{maspf_pkg::OP_SAMPLE,    10'd341,  1'b0, '0},
        '{maspf_pkg::OP_SAMPLE,    10'd682,  1'b0, '0},
        '{maspf_pkg::OP_SAMPLE,    10'd1023, 1'b0, '0}
    };

    multiturn_angle_spring_force uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end

    function automatic bit step_spring(input logic op, input logic [9:0] raw,
                                       output spring_out_t res);
        int          diff;
        int          mag;
        int          offset;
        int          f;
        int unsigned mf;
        int unsigned dt;
        logic [15:0] cum;
        logic [15:0] pos;
        res = '0;
        if (op == maspf_pkg::OP_CALIBRATE)
        begin
            zero_angle  = raw;
            angle_hist1 = raw;
            angle_hist2 = raw;
            return 1'b0;
        end
        diff = int'(raw) - int'(angle_hist2);
        mag  = (diff < 0) ? -diff : diff;
        angle_hist2 = angle_hist1;
        angle_hist1 = raw;
        if (mag > int'(thr_q) && !wrap_flag)
        begin
            wrap_count = (diff > 0) ? wrap_count - 16'd1 : wrap_count + 16'd1;
            wrap_flag  = 1'b1;
        end
        else
        begin
            wrap_flag = 1'b0;
        end
        cum    = 16'({6'b0, raw} + wrap_count * {5'b0, cpf_q});
        pos    = cum - {6'b0, zero_angle};
        offset = int'($signed(center_q)) - int'($signed(pos));
        f      = offset >>> shift_q;
        if (f > 1023)
            f = 1023;
        if (f < -1024)
            f = -1024;
        mf = (f < 0) ? -f : f;
        dt = mf * scale_q;
        if (dt > 65535)
            dt = 65535;
        res.force_val = f[10:0];
        res.reverse   = (f < 0);
        res.duty      = dt[15:0];
        res.pos       = pos;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input logic [47:0] want_v,
                                   input logic [47:0] got_v);
        if (error_cnt < MAX_PRINTS)
            $display("%0t mismatch %s: expected %h, got %h", $time, what, want_v, got_v);
        error_cnt++;
    endtask

    always @(negedge clk)
    begin : result_check
        spring_out_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_spring.size() == 0)
            begin
                report_mismatch("unexpected word", '0, m_tdata);
            end
            else
            begin
                want = pending_spring.pop_front();
                if (m_tdata[10:0] !== want.force_val)
                    report_mismatch("force_res", 48'(want.force_val), 48'(m_tdata[10:0]));
                if (m_tdata[11] !== want.reverse)
                    report_mismatch("drive_reverse", 48'(want.reverse), 48'(m_tdata[11]));
                if (m_tdata[27:12] !== want.duty)
                    report_mismatch("duty", 48'(want.duty), 48'(m_tdata[27:12]));
                if (m_tdata[43:28] !== want.pos)
                    report_mismatch("position", 48'(want.pos), 48'(m_tdata[43:28]));
            end
        end
    end

    task automatic send_word(input logic op, input logic [9:0] raw, input logic pinned,
                             input spring_out_t pinned_res);
        spring_out_t res;
        while ($urandom_range(0, 99) < snd_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'b0, raw};
        do
            @(negedge clk);
        while (!s_tready);
        if (step_spring(op, raw, res))
            pending_spring.push_back(pinned ? pinned_res : res);
        @(posedge clk);
    endtask

    task automatic drain_pipeline();
        s_tvalid <= 1'b0;
        while (pending_spring.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            maspf_pkg::CFG_FLIP_THRESHOLD:  thr_q    = val[9:0];
            maspf_pkg::CFG_COUNTS_PER_FLIP: cpf_q    = val[10:0];
            maspf_pkg::CFG_SPRING_CENTER:   center_q = val;
            maspf_pkg::CFG_FORCE_SHIFT:     shift_q  = val[3:0];
            maspf_pkg::CFG_DUTY_SCALE:      scale_q  = val;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic program_phase(input int unsigned ph);
        case (ph)
            0:
            begin
                write_reg(maspf_pkg::CFG_FLIP_THRESHOLD, 16'd0);
                write_reg(maspf_pkg::CFG_COUNTS_PER_FLIP, 16'd2047);
                write_reg(maspf_pkg::CFG_SPRING_CENTER, 16'h8000);
                write_reg(maspf_pkg::CFG_FORCE_SHIFT, 16'd0);
                write_reg(maspf_pkg::CFG_DUTY_SCALE, 16'hFFFF);
            end
            1:
            begin
                write_reg(maspf_pkg::CFG_FLIP_THRESHOLD, 16'd1023);
                write_reg(maspf_pkg::CFG_COUNTS_PER_FLIP, 16'd0);
                write_reg(maspf_pkg::CFG_SPRING_CENTER, 16'h7FFF);
                write_reg(maspf_pkg::CFG_FORCE_SHIFT, 16'd15);
                write_reg(maspf_pkg::CFG_DUTY_SCALE, 16'd0);
            end
            2:
            begin
                write_reg(maspf_pkg::CFG_FLIP_THRESHOLD, 16'd300);
                write_reg(maspf_pkg::CFG_COUNTS_PER_FLIP, 16'd1024);
                write_reg(maspf_pkg::CFG_SPRING_CENTER, 16'd0);
                write_reg(maspf_pkg::CFG_FORCE_SHIFT, 16'd3);
                write_reg(maspf_pkg::CFG_DUTY_SCALE, 16'd1);
            end
            default:
            begin
                write_reg(maspf_pkg::CFG_FLIP_THRESHOLD, 16'($urandom_range(0, 1023)));
                write_reg(maspf_pkg::CFG_COUNTS_PER_FLIP, 16'($urandom_range(0, 2047)));
                write_reg(maspf_pkg::CFG_SPRING_CENTER, 16'($urandom_range(0, 65535)));
                write_reg(maspf_pkg::CFG_FORCE_SHIFT, 16'($urandom_range(0, 15)));
                write_reg(maspf_pkg::CFG_DUTY_SCALE, 16'($urandom_range(0, 65535)));
            end
        endcase
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_random_word();
        int unsigned kind;
        int          stride;
        logic [9:0]  raw;
        kind = $urandom_range(0, 99);
        if (kind < 4)
        begin
            raw = 10'($urandom_range(0, 1023));
            sweep_angle = raw;
            send_word(maspf_pkg::OP_CALIBRATE, raw, 1'b0, '0);
        end
        else if (kind < 12)
        begin
            send_word(maspf_pkg::OP_SAMPLE, 10'($urandom_range(0, 1023)), 1'b0, '0);
        end
        else
        begin
            if (kind < 20)
                stride = int'($urandom_range(0, 1000)) - 500;
            else
                stride = int'($urandom_range(0, 160)) - 80;
            sweep_angle = 10'(int'(sweep_angle) + stride);
            send_word(maspf_pkg::OP_SAMPLE, sweep_angle, 1'b0, '0);
        end
    endtask

    initial
    begin
        thr_q       = maspf_pkg::RST_FLIP_THRESHOLD;
        cpf_q       = maspf_pkg::RST_COUNTS_PER_FLIP;
        center_q    = maspf_pkg::RST_SPRING_CENTER;
        shift_q     = maspf_pkg::RST_FORCE_SHIFT;
        scale_q     = maspf_pkg::RST_DUTY_SCALE;
        angle_hist1 = '0;
        angle_hist2 = '0;
        wrap_flag   = 1'b0;
        wrap_count  = '0;
        zero_angle  = '0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
            send_word(dir_rows[i].op, dir_rows[i].raw, dir_rows[i].pinned, dir_rows[i].want);
        drain_pipeline();

        for (int unsigned ph = 0; ph < PHASES; ph++)
        begin
            case (ph / 2)
                0:
                begin
                    snd_idle_pct = 21;
                    rcv_idle_pct = 51;
                end
                1:
                begin
                    snd_idle_pct = 51;
                    rcv_idle_pct = 21;
                end
                default:
                begin
                    snd_idle_pct = 0;
                    rcv_idle_pct = 0;
                end
            endcase
            program_phase(ph);
            for (int unsigned n = 0; n < PHASE_WORDS; n++)
                send_random_word();
            drain_pipeline();
        end

        if (error_cnt == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[multiturn_angle_spring_force.f]
sv/maspf_pkg.sv
sv/maspf_unwrap.sv
sv/multiturn_angle_spring_force.sv
verif/tb_multiturn_angle_spring_force.sv
